// ----- design/dls_pkg.sv -----
`default_nettype none

package dls_pkg;

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } dls_op_t;

    localparam int SPACING_BITS = 8;
    localparam logic [SPACING_BITS-1:0] DOT_SPACING_RESET = 8'd4;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;

endpackage

`default_nettype wire

// ----- design/dls_if.sv -----
`default_nettype none

interface dls_in_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dls_out_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  draw_mark;
    logic                  last_point;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, draw_mark, last_point,
                    input ready);
    modport sink (input valid, pixel_valid, pixel_x, pixel_y, draw_mark, last_point,
                  output ready);
endinterface

interface dls_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dls_pkg::SPACING_BITS-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/dls_front.sv -----
`default_nettype none

module dls_front #(
    parameter int COORD_BITS = 12
) (
    dls_in_if.sink                  req,
    output logic                    push_valid,
    input  wire                     push_ready,
    output logic [7*COORD_BITS+4:0] push_data
);

    logic [COORD_BITS-1:0] delta_x;
    logic [COORD_BITS-1:0] delta_y;
    logic                  step_x_back;
    logic                  step_y_back;
    logic [COORD_BITS+1:0] error_init;
    logic                  is_start;

    assign is_start = (dls_pkg::dls_op_t'(req.command) == dls_pkg::OP_START);

    // line setup is stateless, so it is done here before queueing
    always_comb
    begin
        step_x_back = !(req.start_x < req.end_x);
        step_y_back = !(req.start_y < req.end_y);
        delta_x = step_x_back ? (req.start_x - req.end_x) : (req.end_x - req.start_x);
        delta_y = step_y_back ? (req.start_y - req.end_y) : (req.end_y - req.start_y);
        error_init = {2'b00, delta_x} - {2'b00, delta_y};
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;
    assign push_data  = {!is_start, req.start_x, req.start_y, req.end_x, req.end_y,
                         delta_x, delta_y, step_x_back, step_y_back, error_init};

endmodule

`default_nettype wire

// ----- design/dls_queue.sv -----
`default_nettype none

module dls_queue #(
    parameter int WIDTH = 89
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push_valid,
    output logic              push_ready,
    input  wire  [WIDTH-1:0]  push_data,
    output logic              pop_valid,
    input  wire               pop_ready,
    output logic [WIDTH-1:0]  pop_data
);

    localparam int PB = dls_pkg::QUEUE_PTR_BITS;

    logic [WIDTH-1:0] entry_reg [dls_pkg::QUEUE_DEPTH];
    logic [PB-1:0]    wr_ptr_reg;
    logic [PB-1:0]    wr_ptr_next;
    logic [PB-1:0]    rd_ptr_reg;
    logic [PB-1:0]    rd_ptr_next;
    logic [PB:0]      count_reg;
    logic [PB:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PB+1)'(dls_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PB+1)'(do_push) - (PB+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/dls_exec.sv -----
`default_nettype none

module dls_exec #(
    parameter int COORD_BITS = 12
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               pop_valid,
    output logic                              pop_ready,
    input  wire  [7*COORD_BITS+4:0]           pop_data,
    input  wire  [dls_pkg::SPACING_BITS-1:0]  dot_spacing,
    dls_out_if.source                         rsp
);

    localparam int W  = COORD_BITS;
    localparam int SB = dls_pkg::SPACING_BITS;

    // queue entry fields
    logic          op_bit;
    logic [W-1:0]  q_start_x;
    logic [W-1:0]  q_start_y;
    logic [W-1:0]  q_end_x;
    logic [W-1:0]  q_end_y;
    logic [W-1:0]  q_delta_x;
    logic [W-1:0]  q_delta_y;
    logic          q_step_x_back;
    logic          q_step_y_back;
    logic [W+1:0]  q_error;

    assign {op_bit, q_start_x, q_start_y, q_end_x, q_end_y, q_delta_x, q_delta_y,
            q_step_x_back, q_step_y_back, q_error} = pop_data;

    // line state
    logic [W-1:0]   cur_x_reg, cur_x_next;
    logic [W-1:0]   cur_y_reg, cur_y_next;
    logic [W-1:0]   goal_x_reg, goal_x_next;
    logic [W-1:0]   goal_y_reg, goal_y_next;
    logic [W-1:0]   delta_x_reg, delta_x_next;
    logic [W-1:0]   delta_y_reg, delta_y_next;
    logic           step_x_back_reg, step_x_back_next;
    logic           step_y_back_reg, step_y_back_next;
    logic [W+1:0]   error_reg, error_next;
    logic [SB-1:0]  dot_count_reg, dot_count_next;
    logic           line_active_reg, line_active_next;

    // output register
    logic           rsp_valid_reg;
    logic           pixel_valid_reg, pixel_valid_next;
    logic [W-1:0]   pixel_x_reg;
    logic [W-1:0]   pixel_y_reg;
    logic           draw_mark_reg, draw_mark_next;
    logic           last_point_reg, last_point_next;

    logic                 do_item;
    logic                 is_start;
    logic signed [W+2:0]  e2;
    logic signed [W+2:0]  dx_ext;
    logic signed [W+2:0]  dy_ext;
    logic                 move_x;
    logic                 move_y;
    logic [SB-1:0]        spacing;
    logic [SB-1:0]        count_base;
    logic [SB:0]          count_inc;

    assign pop_ready = !rsp_valid_reg || rsp.ready;
    assign do_item   = pop_valid && pop_ready;
    assign is_start  = (dls_pkg::dls_op_t'(op_bit) == dls_pkg::OP_START);

    assign e2     = $signed({error_reg, 1'b0});
    assign dx_ext = $signed({3'b000, delta_x_reg});
    assign dy_ext = $signed({3'b000, delta_y_reg});
    assign move_x = (e2 > -dy_ext);
    assign move_y = (e2 < dx_ext);

    assign spacing = (dot_spacing == '0) ? SB'(1) : dot_spacing;

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        goal_x_next      = goal_x_reg;
        goal_y_next      = goal_y_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        step_x_back_next = step_x_back_reg;
        step_y_back_next = step_y_back_reg;
        error_next       = error_reg;
        dot_count_next   = dot_count_reg;
        line_active_next = line_active_reg;
        pixel_valid_next = 1'b0;
        draw_mark_next   = 1'b0;
        last_point_next  = 1'b0;
        count_base       = '0;
        count_inc        = '0;

        if (is_start || line_active_reg)
        begin
            if (is_start)
            begin
                cur_x_next       = q_start_x;
                cur_y_next       = q_start_y;
                goal_x_next      = q_end_x;
                goal_y_next      = q_end_y;
                delta_x_next     = q_delta_x;
                delta_y_next     = q_delta_y;
                step_x_back_next = q_step_x_back;
                step_y_back_next = q_step_y_back;
                error_next       = q_error;
                count_base       = '0;
            end
            else
            begin
                error_next = error_reg - (move_x ? {2'b00, delta_y_reg} : '0)
                                       + (move_y ? {2'b00, delta_x_reg} : '0);
                if (move_x)
                begin
                    cur_x_next = step_x_back_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (move_y)
                begin
                    cur_y_next = step_y_back_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
                // a lowered spacing takes effect at once
                count_base = (dot_count_reg >= spacing) ? '0 : dot_count_reg;
            end
            draw_mark_next   = (count_base == '0);
            count_inc        = {1'b0, count_base} + 1'b1;
            dot_count_next   = (count_inc >= {1'b0, spacing}) ? '0 : count_inc[SB-1:0];
            last_point_next  = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
            line_active_next = !last_point_next;
            pixel_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            dot_count_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (do_item)
            begin
                line_active_reg <= line_active_next;
                dot_count_reg   <= dot_count_next;
            end
            if (pop_ready)
            begin
                rsp_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_item)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            goal_x_reg      <= goal_x_next;
            goal_y_reg      <= goal_y_next;
            delta_x_reg     <= delta_x_next;
            delta_y_reg     <= delta_y_next;
            step_x_back_reg <= step_x_back_next;
            step_y_back_reg <= step_y_back_next;
            error_reg       <= error_next;
            pixel_valid_reg <= pixel_valid_next;
            pixel_x_reg     <= pixel_valid_next ? cur_x_next : '0;
            pixel_y_reg     <= pixel_valid_next ? cur_y_next : '0;
            draw_mark_reg   <= draw_mark_next;
            last_point_reg  <= last_point_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.pixel_valid = pixel_valid_reg;
    assign rsp.pixel_x     = pixel_x_reg;
    assign rsp.pixel_y     = pixel_y_reg;
    assign rsp.draw_mark   = draw_mark_reg;
    assign rsp.last_point  = last_point_reg;

endmodule

`default_nettype wire

// ----- design/dotted_line_stepper.sv -----
// Dotted Bresenham line stepper for all octants. A start transfer on req loads both
// endpoints and returns the first point, always marked; each advance transfer returns the
// next pixel with a draw mark (one pixel in dot_spacing, zero acting as one) and a last
// mark at the end point, after which the block is idle and advances return a result with
// pixel_valid clear. Throughput is one item per clock when rsp is not stalled: the front does
// the line setup and writes a four-entry queue, and the back runs the error update and dot
// counter for each item into an output register, so a req transfer reaches rsp through the
// queue entry and then the output register. The queue lets req keep taking items while a
// result waits on rsp. dot_spacing is written through cfg, always ready.
`default_nettype none

module dotted_line_stepper #(
    parameter int COORD_BITS = 12
) (
    input  wire        clk,
    input  wire        rst_n,
    dls_in_if.sink     req,
    dls_out_if.source  rsp,
    dls_cfg_if.sink    cfg
);

    localparam int ENTRY_BITS = 7*COORD_BITS + 5;

    logic                              push_valid;
    logic                              push_ready;
    logic [ENTRY_BITS-1:0]             push_data;
    logic                              pop_valid;
    logic                              pop_ready;
    logic [ENTRY_BITS-1:0]             pop_data;
    logic [dls_pkg::SPACING_BITS-1:0]  dot_spacing_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_spacing_reg <= dls_pkg::DOT_SPACING_RESET;
        end
        else if (cfg.valid)
        begin
            dot_spacing_reg <= cfg.data;
        end
    end

    dls_front #(.COORD_BITS(COORD_BITS)) u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dls_queue #(.WIDTH(ENTRY_BITS)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dls_exec #(.COORD_BITS(COORD_BITS)) u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .dot_spacing (dot_spacing_reg),
        .rsp         (rsp)
    );

    // an idle advance carries no point and no marks
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.pixel_valid |->
            !rsp.draw_mark && !rsp.last_point && rsp.pixel_x == '0 && rsp.pixel_y == '0)
    else $error("idle result carries point data");

    // the end point is only flagged on a real point
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.last_point |-> rsp.pixel_valid)
    else $error("last mark without a point");

    // a stalled result stays on rsp until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("pending result dropped");

endmodule

`default_nettype wire
